[hw/rtl/dpcc_pkg.sv]
package dpcc_pkg;

  // Fixed field widths
  localparam int TAG_W   = 32;
  localparam int CLASS_W = 8;
  localparam int CONF_W  = 16;
  localparam int DEC_W   = 8;

  // Item operation codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPARE = 1'b1;

  // Register indexes (byte address / 4)
  localparam int          REG_IDX_W    = 2;
  localparam logic [1:0]  REG_CONF_GAP = 2'd0;
  localparam logic [1:0]  REG_DIST_SQ  = 2'd1;
  localparam logic [1:0]  REG_NORMAL   = 2'd2;
  localparam logic [1:0]  REG_CRITICAL = 2'd3;

  // Register reset values
  localparam logic [15:0] CONF_GAP_RST = 16'd16384;
  localparam logic [31:0] DIST_SQ_RST  = 32'd25600;
  localparam logic [7:0]  NORMAL_RST   = 8'd1;
  localparam logic [7:0]  CRITICAL_RST = 8'd2;

  // Conflict reason codes
  localparam logic [1:0] REASON_CLASS  = 2'd0;
  localparam logic [1:0] REASON_CONF   = 2'd1;
  localparam logic [1:0] REASON_ACTION = 2'd2;

  // Severity codes
  localparam logic [1:0] SEV_LOW      = 2'd0;
  localparam logic [1:0] SEV_MEDIUM   = 2'd1;
  localparam logic [1:0] SEV_HIGH     = 2'd2;
  localparam logic [1:0] SEV_CRITICAL = 2'd3;

  typedef struct packed {
    logic [CONF_W-1:0]  conf_gap_limit;
    logic [31:0]        dist_sq_limit;
    logic [DEC_W-1:0]   normal_code;
    logic [DEC_W-1:0]   critical_code;
  } cfg_t;

  typedef struct packed {
    logic       same_target;
    logic       box_overlap_match;
    logic       conflict;
    logic [1:0] reason;
    logic [1:0] severity;
  } res_t;

endpackage

[hw/rtl/dpcc_eval.sv]
module dpcc_eval
  import dpcc_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int GEO_BITS   = 20
) (
  input  cfg_t                         cfg,
  input  logic [TAG_W-1:0]             ref_tag,
  input  logic [COORD_BITS-1:0]        ref_box_x,
  input  logic [COORD_BITS-1:0]        ref_box_y,
  input  logic [COORD_BITS-1:0]        ref_box_w,
  input  logic [COORD_BITS-1:0]        ref_box_h,
  input  logic signed [GEO_BITS-1:0]   ref_geo_x,
  input  logic signed [GEO_BITS-1:0]   ref_geo_y,
  input  logic [CLASS_W-1:0]           ref_class,
  input  logic [CONF_W-1:0]            ref_confidence,
  input  logic [DEC_W-1:0]             ref_decision,
  input  logic [TAG_W-1:0]             peer_tag,
  input  logic [COORD_BITS-1:0]        peer_box_x,
  input  logic [COORD_BITS-1:0]        peer_box_y,
  input  logic [COORD_BITS-1:0]        peer_box_w,
  input  logic [COORD_BITS-1:0]        peer_box_h,
  input  logic signed [GEO_BITS-1:0]   peer_geo_x,
  input  logic signed [GEO_BITS-1:0]   peer_geo_y,
  input  logic [CLASS_W-1:0]           peer_class,
  input  logic [CONF_W-1:0]            peer_conf,
  input  logic [DEC_W-1:0]             peer_dec,
  output res_t                         res
);

  localparam int UW   = 2*COORD_BITS + 3;
  localparam int SQ_W = (2*GEO_BITS + 3 > 32) ? 2*GEO_BITS + 3 : 32;

  // Box overlap
  logic [COORD_BITS:0]     ref_end_x, ref_end_y, peer_end_x, peer_end_y;
  logic [COORD_BITS:0]     lo_x, lo_y, hi_x, hi_y;
  logic [COORD_BITS:0]     span_x, span_y;
  logic [2*COORD_BITS+1:0] inter;
  logic [2*COORD_BITS-1:0] area_ref, area_peer;
  logic [UW-1:0]           uni, two_inter;
  logic                    boxes_valid, overlap;

  // Geo distance
  logic signed [GEO_BITS:0] dx, dy;
  logic [GEO_BITS:0]        adx, ady;
  logic [2*GEO_BITS+1:0]    sqx, sqy;
  logic [SQ_W-1:0]          dist_sq;
  logic                     geo_near;

  // Decision terms
  logic [CONF_W:0] cdiff, acdiff;
  logic            tag_match, same, cls_c, conf_c, act_c, conflict, crit_pair;

  assign ref_end_x  = {1'b0, ref_box_x}  + {1'b0, ref_box_w};
  assign ref_end_y  = {1'b0, ref_box_y}  + {1'b0, ref_box_h};
  assign peer_end_x = {1'b0, peer_box_x} + {1'b0, peer_box_w};
  assign peer_end_y = {1'b0, peer_box_y} + {1'b0, peer_box_h};

  assign lo_x = (ref_box_x > peer_box_x) ? {1'b0, ref_box_x} : {1'b0, peer_box_x};
  assign lo_y = (ref_box_y > peer_box_y) ? {1'b0, ref_box_y} : {1'b0, peer_box_y};
  assign hi_x = (ref_end_x < peer_end_x) ? ref_end_x : peer_end_x;
  assign hi_y = (ref_end_y < peer_end_y) ? ref_end_y : peer_end_y;

  assign span_x = hi_x - lo_x;
  assign span_y = hi_y - lo_y;
  assign inter  = span_x * span_y;

  assign area_ref  = ref_box_w * ref_box_h;
  assign area_peer = peer_box_w * peer_box_h;

  // inter never exceeds either area when the boxes overlap, so no underflow
  assign uni       = UW'(area_ref) + UW'(area_peer) - UW'(inter);
  assign two_inter = {inter, 1'b0};

  assign boxes_valid = (ref_box_w != '0) && (ref_box_h != '0) &&
                       (peer_box_w != '0) && (peer_box_h != '0);
  assign overlap = boxes_valid && (hi_x > lo_x) && (hi_y > lo_y) && (two_inter > uni);

  assign dx  = {ref_geo_x[GEO_BITS-1], ref_geo_x} - {peer_geo_x[GEO_BITS-1], peer_geo_x};
  assign dy  = {ref_geo_y[GEO_BITS-1], ref_geo_y} - {peer_geo_y[GEO_BITS-1], peer_geo_y};
  assign adx = dx[GEO_BITS] ? (GEO_BITS+1)'(-dx) : (GEO_BITS+1)'(dx);
  assign ady = dy[GEO_BITS] ? (GEO_BITS+1)'(-dy) : (GEO_BITS+1)'(dy);
  assign sqx = adx * adx;
  assign sqy = ady * ady;
  assign dist_sq  = SQ_W'(sqx) + SQ_W'(sqy);
  assign geo_near = ((ref_geo_x != '0) || (ref_geo_y != '0)) &&
                    (dist_sq < SQ_W'(cfg.dist_sq_limit));

  assign tag_match = (ref_tag != '0) && (ref_tag == peer_tag);
  assign same      = tag_match || overlap || geo_near;

  assign cdiff  = {1'b0, ref_confidence} - {1'b0, peer_conf};
  assign acdiff = cdiff[CONF_W] ? -cdiff : cdiff;

  assign cls_c    = ref_class != peer_class;
  assign conf_c   = acdiff > {1'b0, cfg.conf_gap_limit};
  assign act_c    = ref_decision != peer_dec;
  assign conflict = same && (cls_c || conf_c || act_c);

  assign crit_pair = ((ref_decision == cfg.critical_code) &&
                      (peer_dec == cfg.normal_code)) ||
                     ((ref_decision == cfg.normal_code) &&
                      (peer_dec == cfg.critical_code));

  always_comb begin
    res.same_target       = same;
    res.box_overlap_match = overlap;
    res.conflict          = conflict;
    res.reason            = REASON_CLASS;
    res.severity          = SEV_LOW;
    if (conflict) begin
      priority if (cls_c) begin
        res.reason = REASON_CLASS;
      end else if (conf_c) begin
        res.reason = REASON_CONF;
      end else begin
        res.reason = REASON_ACTION;
      end
      priority if (crit_pair) begin
        res.severity = SEV_CRITICAL;
      end else if (cls_c) begin
        res.severity = SEV_HIGH;
      end else if (conf_c) begin
        res.severity = SEV_MEDIUM;
      end else begin
        res.severity = SEV_LOW;
      end
    end
  end

endmodule

[hw/rtl/detection_pair_conflict_check.sv]
// Detection pair conflict check.
//
// Input channel (in_valid / in_stall): one transaction per detection. A load
// transaction (in_operation = load) replaces the held reference detection and
// yields no result. A compare transaction checks the peer detection against
// the reference and yields exactly one result transaction.
// Result channel (out_valid / out_stall): same_target, box_overlap_match,
// conflict, reason and severity for each compare, in input order.
// Configuration: APB-style write/read port, registers at byte offsets 0x0
// (confidence gap limit), 0x4 (squared distance limit), 0x8 (normal code)
// and 0xC (critical code). Write only while no transaction is in flight.
// Path: an accepted compare is held in the input register, then its result in the
// result register. Throughput: one per cycle unless out_stall holds a result,
// set by the single evaluation stage between the two registers.
// Stall: while out_stall holds a result, the input register still drains a
// load; a waiting compare holds and in_stall rises only when it cannot move.
// Reset: clears the reference detection to zero (never the same target),
// loads register defaults, and empties both stages.
module detection_pair_conflict_check
  import dpcc_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int GEO_BITS   = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,

  // Input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_operation,
  input  logic [TAG_W-1:0]            in_target_tag,
  input  logic [COORD_BITS-1:0]       in_box_x,
  input  logic [COORD_BITS-1:0]       in_box_y,
  input  logic [COORD_BITS-1:0]       in_box_w,
  input  logic [COORD_BITS-1:0]       in_box_h,
  input  logic signed [GEO_BITS-1:0]  in_geo_x,
  input  logic signed [GEO_BITS-1:0]  in_geo_y,
  input  logic [CLASS_W-1:0]          in_class_code,
  input  logic [CONF_W-1:0]           in_confidence,
  input  logic [DEC_W-1:0]            in_decision_code,

  // Result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_same_target,
  output logic                        out_box_overlap_match,
  output logic                        out_conflict,
  output logic [1:0]                  out_reason,
  output logic [1:0]                  out_severity,

  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  cfg_t                 cfg_r;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.conf_gap_limit <= CONF_GAP_RST;
      cfg_r.dist_sq_limit  <= DIST_SQ_RST;
      cfg_r.normal_code    <= NORMAL_RST;
      cfg_r.critical_code  <= CRITICAL_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CONF_GAP: cfg_r.conf_gap_limit <= pwdata[CONF_W-1:0];
        REG_DIST_SQ:  cfg_r.dist_sq_limit  <= pwdata;
        REG_NORMAL:   cfg_r.normal_code    <= pwdata[DEC_W-1:0];
        REG_CRITICAL: cfg_r.critical_code  <= pwdata[DEC_W-1:0];
      endcase
    end
  end

  // Read back: zero-extend each register to the bus
  always_comb begin
    unique case (cfg_idx)
      REG_CONF_GAP: prdata = 32'(cfg_r.conf_gap_limit);
      REG_DIST_SQ:  prdata = cfg_r.dist_sq_limit;
      REG_NORMAL:   prdata = 32'(cfg_r.normal_code);
      REG_CRITICAL: prdata = 32'(cfg_r.critical_code);
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free, s1_move, in_accept, ref_load, out_load;

  // Input register payload (no reset)
  logic                       s1_op_r;
  logic [TAG_W-1:0]           s1_tag_r;
  logic [COORD_BITS-1:0]      s1_box_x_r, s1_box_y_r, s1_box_w_r, s1_box_h_r;
  logic signed [GEO_BITS-1:0] s1_geo_x_r, s1_geo_y_r;
  logic [CLASS_W-1:0]         s1_class_r;
  logic [CONF_W-1:0]          s1_conf_r;
  logic [DEC_W-1:0]           s1_dec_r;

  // The result register is free when empty or being drained this cycle.
  assign out_free  = !out_valid_r || !out_stall;
  // A load always leaves; a compare needs room in the result register.
  assign s1_move   = s1_valid_r && ((s1_op_r == OP_LOAD) || out_free);
  assign in_stall  = s1_valid_r && !s1_move;
  assign in_accept = in_valid && !in_stall;
  // Update the reference in order, as the load leaves the input register,
  // so earlier compares still see the old reference.
  assign ref_load  = s1_move && (s1_op_r == OP_LOAD);
  assign out_load  = s1_move && (s1_op_r == OP_COMPARE);

  always_comb begin
    s1_valid_nxt  = in_accept || (s1_valid_r && !s1_move);
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r    <= in_operation;
      s1_tag_r   <= in_target_tag;
      s1_box_x_r <= in_box_x;
      s1_box_y_r <= in_box_y;
      s1_box_w_r <= in_box_w;
      s1_box_h_r <= in_box_h;
      s1_geo_x_r <= in_geo_x;
      s1_geo_y_r <= in_geo_y;
      s1_class_r <= in_class_code;
      s1_conf_r  <= in_confidence;
      s1_dec_r   <= in_decision_code;
    end
  end

  // ---------------------------------------------------------------------
  // Reference detection, cleared by reset
  // ---------------------------------------------------------------------
  logic [TAG_W-1:0]           ref_tag_r;
  logic [COORD_BITS-1:0]      ref_box_x_r, ref_box_y_r, ref_box_w_r, ref_box_h_r;
  logic signed [GEO_BITS-1:0] ref_geo_x_r, ref_geo_y_r;
  logic [CLASS_W-1:0]         ref_class_r;
  logic [CONF_W-1:0]          ref_conf_r;
  logic [DEC_W-1:0]           ref_dec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_tag_r   <= '0;
      ref_box_x_r <= '0;
      ref_box_y_r <= '0;
      ref_box_w_r <= '0;
      ref_box_h_r <= '0;
      ref_geo_x_r <= '0;
      ref_geo_y_r <= '0;
      ref_class_r <= '0;
      ref_conf_r  <= '0;
      ref_dec_r   <= '0;
    end else if (ref_load) begin
      ref_tag_r   <= s1_tag_r;
      ref_box_x_r <= s1_box_x_r;
      ref_box_y_r <= s1_box_y_r;
      ref_box_w_r <= s1_box_w_r;
      ref_box_h_r <= s1_box_h_r;
      ref_geo_x_r <= s1_geo_x_r;
      ref_geo_y_r <= s1_geo_y_r;
      ref_class_r <= s1_class_r;
      ref_conf_r  <= s1_conf_r;
      ref_dec_r   <= s1_dec_r;
    end
  end

  // ---------------------------------------------------------------------
  // Evaluation and result register
  // ---------------------------------------------------------------------
  res_t eval_res;
  res_t out_r;

  dpcc_eval #(
    .COORD_BITS (COORD_BITS),
    .GEO_BITS   (GEO_BITS)
  ) u_eval (
    .cfg             (cfg_r),
    .ref_tag         (ref_tag_r),
    .ref_box_x       (ref_box_x_r),
    .ref_box_y       (ref_box_y_r),
    .ref_box_w       (ref_box_w_r),
    .ref_box_h       (ref_box_h_r),
    .ref_geo_x       (ref_geo_x_r),
    .ref_geo_y       (ref_geo_y_r),
    .ref_class       (ref_class_r),
    .ref_confidence  (ref_conf_r),
    .ref_decision    (ref_dec_r),
    .peer_tag        (s1_tag_r),
    .peer_box_x      (s1_box_x_r),
    .peer_box_y      (s1_box_y_r),
    .peer_box_w      (s1_box_w_r),
    .peer_box_h      (s1_box_h_r),
    .peer_geo_x      (s1_geo_x_r),
    .peer_geo_y      (s1_geo_y_r),
    .peer_class      (s1_class_r),
    .peer_conf       (s1_conf_r),
    .peer_dec        (s1_dec_r),
    .res             (eval_res)
  );

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= eval_res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_same_target       = out_r.same_target;
  assign out_box_overlap_match = out_r.box_overlap_match;
  assign out_conflict          = out_r.conflict;
  assign out_reason            = out_r.reason;
  assign out_severity          = out_r.severity;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_conflict_needs_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_r.conflict || out_r.same_target))
    else $error("conflict reported without same target");

  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.conflict) |->
      (out_r.reason == REASON_CLASS && out_r.severity == SEV_LOW))
    else $error("reason or severity set without conflict");

  a_ref_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !ref_load |=> ($stable(ref_tag_r) && $stable(ref_dec_r) && $stable(ref_box_w_r)))
    else $error("reference changed without a load leaving the input register");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled result lost or changed");

  a_reset_ref: assert property (@(posedge clk)
    !rst_n |=> (ref_tag_r == '0 && ref_box_w_r == '0 && !s1_valid_r && !out_valid_r))
    else $error("reset did not clear reference and pipeline");

endmodule

[tb/tb_detection_pair_conflict_check.sv]
module tb_detection_pair_conflict_check;
  import dpcc_pkg::*;

  localparam int CB = 12;            // box coordinate width
  localparam int GB = 20;            // geo coordinate width
  localparam int SETTLE_CYCLES = 4;  // wait after the last owed verdict for the pipeline to settle
  localparam int CYCLE_LIMIT = 400000;
  localparam int VERDICT_DEPTH = 16; // far more than the block can hold in flight

  // Receiver stall patterns
  localparam int STALL_NONE  = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;

  // One detection as carried by an input transaction
  typedef struct {
    logic                 op;
    logic [TAG_W-1:0]     tag;
    logic [CB-1:0]        bx;
    logic [CB-1:0]        by;
    logic [CB-1:0]        bw;
    logic [CB-1:0]        bh;
    logic signed [GB-1:0] gx;
    logic signed [GB-1:0] gy;
    logic [CLASS_W-1:0]   cls;
    logic [CONF_W-1:0]    conf;
    logic [DEC_W-1:0]     dec;
  } detection_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                 in_valid;
  logic                 in_stall;
  logic                 in_operation;
  logic [TAG_W-1:0]     in_target_tag;
  logic [CB-1:0]        in_box_x;
  logic [CB-1:0]        in_box_y;
  logic [CB-1:0]        in_box_w;
  logic [CB-1:0]        in_box_h;
  logic signed [GB-1:0] in_geo_x;
  logic signed [GB-1:0] in_geo_y;
  logic [CLASS_W-1:0]   in_class_code;
  logic [CONF_W-1:0]    in_confidence;
  logic [DEC_W-1:0]     in_decision_code;

  logic       out_valid;
  logic       out_stall;
  logic       out_same_target;
  logic       out_box_overlap_match;
  logic       out_conflict;
  logic [1:0] out_reason;
  logic [1:0] out_severity;

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the block: held reference detection and register values
  detection_t          held_ref;
  logic [CONF_W-1:0]   gap_limit;
  logic [31:0]         dist_limit;
  logic [DEC_W-1:0]    normal_code;
  logic [DEC_W-1:0]    critical_code;

  // Verdicts still owed by the block, oldest at the read count
  res_t verdict_fifo [VERDICT_DEPTH];
  int   verdict_wr = 0;
  int   verdict_rd = 0;
  res_t arrived_want;

  int errors = 0;
  int cycle_count = 0;
  int stall_mode = STALL_NONE;
  int hold_request = 0;
  int hold_left = 0;
  int run_left = 0;
  logic stall_run = 1'b0;
  int burst_left = 0;

  detection_pair_conflict_check i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_operation          (in_operation),
    .in_target_tag         (in_target_tag),
    .in_box_x              (in_box_x),
    .in_box_y              (in_box_y),
    .in_box_w              (in_box_w),
    .in_box_h              (in_box_h),
    .in_geo_x              (in_geo_x),
    .in_geo_y              (in_geo_y),
    .in_class_code         (in_class_code),
    .in_confidence         (in_confidence),
    .in_decision_code      (in_decision_code),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_same_target       (out_same_target),
    .out_box_overlap_match (out_box_overlap_match),
    .out_conflict          (out_conflict),
    .out_reason            (out_reason),
    .out_severity          (out_severity),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bound the run; a hang anywhere ends here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Verdict prediction: judge a peer detection against the held reference
  // ---------------------------------------------------------------------------
  function automatic res_t judge_pair(detection_t peer);
    res_t v;
    longint unsigned ax, ay, aw, ah, bx, by, bw, bh;
    longint unsigned lo_x, lo_y, hi_x, hi_y, inter, uni, dist_val;
    longint dx, dy;
    int gap;
    logic cls_c, conf_c, act_c;
    v = '0;
    ax = 64'(held_ref.bx); ay = 64'(held_ref.by);
    aw = 64'(held_ref.bw); ah = 64'(held_ref.bh);
    bx = 64'(peer.bx); by = 64'(peer.by); bw = 64'(peer.bw); bh = 64'(peer.bh);
    // Zero-size boxes never overlap; edge sums are formed wide, no wrap
    if (aw != 0 && ah != 0 && bw != 0 && bh != 0) begin
      lo_x = (ax > bx) ? ax : bx;
      lo_y = (ay > by) ? ay : by;
      hi_x = (ax + aw < bx + bw) ? ax + aw : bx + bw;
      hi_y = (ay + ah < by + bh) ? ay + ah : by + bh;
      if (hi_x > lo_x && hi_y > lo_y) begin
        inter = (hi_x - lo_x) * (hi_y - lo_y);
        uni = aw * ah + bw * bh - inter;
        v.box_overlap_match = (2 * inter > uni);
      end
    end
    v.same_target = (held_ref.tag != '0 && held_ref.tag == peer.tag) || v.box_overlap_match;
    // Geo proximity counts only when the reference has a position
    if (!v.same_target && (held_ref.gx != '0 || held_ref.gy != '0)) begin
      dx = 64'(held_ref.gx);
      dx = dx - 64'(peer.gx);
      dy = 64'(held_ref.gy);
      dy = dy - 64'(peer.gy);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      dist_val = dx * dx + dy * dy;
      if (dist_val < 64'(dist_limit)) v.same_target = 1'b1;
    end
    // Raw confidences, no saturation above one
    gap = int'(held_ref.conf) - int'(peer.conf);
    if (gap < 0) gap = -gap;
    cls_c = held_ref.cls != peer.cls;
    conf_c = gap > int'(gap_limit);
    act_c = held_ref.dec != peer.dec;
    v.conflict = v.same_target && (cls_c || conf_c || act_c);
    if (v.conflict) begin
      v.reason = cls_c ? REASON_CLASS : (conf_c ? REASON_CONF : REASON_ACTION);
      if ((held_ref.dec == critical_code && peer.dec == normal_code) ||
          (held_ref.dec == normal_code && peer.dec == critical_code))
        v.severity = SEV_CRITICAL;
      else if (cls_c)
        v.severity = SEV_HIGH;
      else if (conf_c)
        v.severity = SEV_MEDIUM;
      else
        v.severity = SEV_LOW;
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Compare every accepted result transaction with the oldest verdict owed
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_wr == verdict_rd) begin
        $error("result: expected none, actual one arrived");
        errors++;
      end else begin
        arrived_want = verdict_fifo[verdict_rd % VERDICT_DEPTH];
        verdict_rd++;
        check_field("same_target", int'(arrived_want.same_target),
                    int'(out_same_target));
        check_field("box_overlap_match", int'(arrived_want.box_overlap_match),
                    int'(out_box_overlap_match));
        check_field("conflict", int'(arrived_want.conflict), int'(out_conflict));
        check_field("reason", int'(arrived_want.reason), int'(out_reason));
        check_field("severity", int'(arrived_want.severity), int'(out_severity));
      end
    end
  end

  // Receiver: stall in runs of random length; a requested hold overrides all
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 8);
          case (stall_mode)
            STALL_NONE:  stall_run = 1'b0;
            STALL_LIGHT: stall_run = ($urandom_range(0, 3) == 0);
            default:     stall_run = ($urandom_range(0, 2) != 0);
          endcase
        end
        run_left--;
        out_stall <= stall_run;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Offer one detection and hold it until accepted; record what it should do
  task automatic send_detection(detection_t d);
    @(negedge clk);
    in_valid         <= 1'b1;
    in_operation     <= d.op;
    in_target_tag    <= d.tag;
    in_box_x         <= d.bx;
    in_box_y         <= d.by;
    in_box_w         <= d.bw;
    in_box_h         <= d.bh;
    in_geo_x         <= d.gx;
    in_geo_y         <= d.gy;
    in_class_code    <= d.cls;
    in_confidence    <= d.conf;
    in_decision_code <= d.dec;
    do @(posedge clk); while (in_stall);
    if (d.op == OP_COMPARE) begin
      verdict_fifo[verdict_wr % VERDICT_DEPTH] = judge_pair(d);
      verdict_wr++;
    end else begin
      held_ref = d;
    end
  endtask

  // Drop valid for a while; scramble part of the payload so idle data never matters
  task automatic pause_sender(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid      <= 1'b0;
      in_target_tag <= $urandom;
      in_confidence <= CONF_W'($urandom);
      in_box_w      <= CB'($urandom);
    end
  endtask

  // Send in bursts of random length, with random gaps between bursts
  task automatic send_paced(detection_t d);
    send_detection(d);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      pause_sender($urandom_range(1, 8));
    end
  endtask

  // Stop offering, wait for every owed verdict, then let the pipeline settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_wr != verdict_rd) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic detection_t make_det(logic op, logic [TAG_W-1:0] tag,
                                          int bx, int by, int bw, int bh,
                                          int gx, int gy, int cls, int conf, int dec);
    detection_t d;
    d.op = op;
    d.tag = tag;
    d.bx = CB'(bx); d.by = CB'(by); d.bw = CB'(bw); d.bh = CB'(bh);
    d.gx = GB'(gx); d.gy = GB'(gy);
    d.cls = CLASS_W'(cls); d.conf = CONF_W'(conf); d.dec = DEC_W'(dec);
    return d;
  endfunction

  // Fully random detection, operation included, confidence over all 16 bits
  function automatic detection_t random_noise();
    detection_t d;
    d.op = 1'($urandom);
    d.tag = $urandom;
    d.bx = CB'($urandom); d.by = CB'($urandom);
    d.bw = CB'($urandom); d.bh = CB'($urandom);
    d.gx = GB'($urandom); d.gy = GB'($urandom);
    d.cls = CLASS_W'($urandom); d.conf = CONF_W'($urandom); d.dec = DEC_W'($urandom);
    return d;
  endfunction

  // Reference detection with a mix of empty tags, boxes and positions
  function automatic detection_t random_load();
    detection_t d;
    d = random_noise();
    d.op = OP_LOAD;
    if ($urandom_range(0, 4) == 0) d.tag = '0;
    d.bx = CB'($urandom_range(0, 4095));
    d.by = CB'($urandom_range(0, 4095));
    case ($urandom_range(0, 9))
      0:       begin d.bw = '0; d.bh = CB'($urandom_range(0, 300)); end
      1, 2:    begin d.bw = CB'($urandom); d.bh = CB'($urandom); end
      default: begin
        d.bw = CB'($urandom_range(1, 300));
        d.bh = CB'($urandom_range(1, 300));
      end
    endcase
    case ($urandom_range(0, 19))
      0, 1, 2: begin d.gx = '0; d.gy = '0; end
      3:       d.gx = '0;
      4:       d.gy = '0;
      default: ;
    endcase
    if ($urandom_range(0, 19) != 0) d.conf = CONF_W'($urandom_range(0, 32768));
    case ($urandom_range(0, 3))
      0: d.dec = normal_code;
      1: d.dec = critical_code;
      default: ;
    endcase
    return d;
  endfunction

  // Peer detection close to the held reference so that every test path fires
  function automatic detection_t near_compare();
    detection_t d;
    logic signed [GB-1:0] delta;
    d = random_noise();
    d.op = OP_COMPARE;
    if ($urandom_range(0, 1) == 0) d.tag = held_ref.tag;
    else if ($urandom_range(0, 9) == 0) d.tag = '0;
    if ($urandom_range(0, 4) < 3) begin
      d.bx = CB'(held_ref.bx + $urandom_range(0, 16) - 8);
      d.by = CB'(held_ref.by + $urandom_range(0, 16) - 8);
      d.bw = CB'(held_ref.bw + $urandom_range(0, 16) - 8);
      d.bh = CB'(held_ref.bh + $urandom_range(0, 16) - 8);
    end
    if ($urandom_range(0, 1) == 0) begin
      delta = GB'($urandom_range(0, 400) - 200);
      d.gx = held_ref.gx + delta;
      delta = GB'($urandom_range(0, 400) - 200);
      d.gy = held_ref.gy + delta;
    end
    if ($urandom_range(0, 9) < 7) d.cls = held_ref.cls;
    case ($urandom_range(0, 19))
      0:       ;
      1, 2:    d.conf = held_ref.conf;
      default: d.conf = CONF_W'(held_ref.conf + $urandom_range(0, 40000) - 20000);
    endcase
    case ($urandom_range(0, 5))
      0, 1, 2: d.dec = held_ref.dec;
      3:       d.dec = normal_code;
      4:       d.dec = critical_code;
      default: ;
    endcase
    return d;
  endfunction

  // Mostly a load followed by a run of related compares; some raw noise
  task automatic random_traffic(int count);
    int sent;
    int run;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 85) begin
        send_paced(random_load());
        run = $urandom_range(1, 10);
        repeat (run) send_paced(near_compare());
        sent += run + 1;
      end else begin
        send_paced(random_noise());
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  // Read a register back and compare it with the shadow value
  task automatic check_reg(logic [REG_IDX_W-1:0] idx);
    logic [31:0] want;
    logic [31:0] mask;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CONF_GAP: begin want = 32'(gap_limit);     mask = 32'h0000_ffff; end
      REG_DIST_SQ:  begin want = dist_limit;         mask = 32'hffff_ffff; end
      REG_NORMAL:   begin want = 32'(normal_code);   mask = 32'h0000_00ff; end
      default:      begin want = 32'(critical_code); mask = 32'h0000_00ff; end
    endcase
    check_field($sformatf("register %0d", idx), want, prdata & mask);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Setup cycle, access cycle, then read back
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CONF_GAP: gap_limit     = value[CONF_W-1:0];
      REG_DIST_SQ:  dist_limit    = value;
      REG_NORMAL:   normal_code   = value[DEC_W-1:0];
      default:      critical_code = value[DEC_W-1:0];
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_reg(idx);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_register_defaults();
    check_reg(REG_CONF_GAP);
    check_reg(REG_DIST_SQ);
    check_reg(REG_NORMAL);
    check_reg(REG_CRITICAL);
  endtask

  // The reset reference has no tag, no box and no position: never a match
  task automatic test_compare_before_load();
    stall_mode = STALL_NONE;
    send_detection(make_det(OP_COMPARE, '0, 0, 0, 5, 5, 0, 0, 0, 0, 0));
    send_detection(make_det(OP_COMPARE, 32'hffff_ffff, 0, 0, 4095, 4095, 1, 1, 3, 32768, 2));
    send_detection(make_det(OP_COMPARE, 32'h1, 4095, 4095, 4095, 4095, -524288, 524287,
                            255, 65535, 255));
    wait_drained();
  endtask

  task automatic test_directed_cases();
    stall_mode = STALL_LIGHT;
    // Reference with tag, box, class and geo y at their top; box runs past the coordinate range
    send_detection(make_det(OP_LOAD, 32'hffff_ffff, 4095, 4095, 4095, 4095,
                            -524288, 524287, 255, 32768, 1));
    // Class mismatch between normal and critical decisions
    send_detection(make_det(OP_COMPARE, 32'hffff_ffff, 4095, 4095, 4095, 4095,
                            -524288, 524287, 0, 0, 2));
    // Box match alone, confidence gap only
    send_detection(make_det(OP_COMPARE, 32'h1, 4095, 4095, 4095, 4095,
                            0, 0, 255, 0, 1));
    // Tag match, zero-width peer box, identical content
    send_detection(make_det(OP_COMPARE, 32'hffff_ffff, 4095, 4095, 0, 4095,
                            0, 0, 255, 32768, 1));
    // Action conflict only
    send_detection(make_det(OP_COMPARE, 32'hffff_ffff, 4095, 4095, 4095, 4095,
                            -524288, 524287, 255, 32768, 200));
    // Geo proximity alone
    send_detection(make_det(OP_COMPARE, '0, 0, 0, 1, 1, -524278, 524277, 255, 32768, 1));
    // Far geo, nothing in common
    send_detection(make_det(OP_COMPARE, '0, 0, 0, 1, 1, 524287, -524288, 0, 0, 0));

    // Reference without tag or position
    send_detection(make_det(OP_LOAD, '0, 100, 100, 100, 100, 0, 0, 7, 16384, 2));
    // IoU exactly one half does not match; geo ignored at zero reference
    send_detection(make_det(OP_COMPARE, '0, 100, 100, 100, 50, 1, 1, 8, 16384, 1));
    // Just over one half, class mismatch, critical against normal
    send_detection(make_det(OP_COMPARE, '0, 100, 100, 100, 51, 0, 0, 8, 16384, 1));
    // Confidence gap equal to the limit is no conflict
    send_detection(make_det(OP_COMPARE, '0, 100, 100, 100, 100, 0, 0, 7, 32768, 2));
    // Confidence above one, one past the limit
    send_detection(make_det(OP_COMPARE, '0, 100, 100, 100, 100, 0, 0, 7, 32769, 2));
    send_detection(make_det(OP_COMPARE, '0, 100, 100, 100, 100, 0, 0, 7, 65535, 1));
    // Touching boxes do not overlap
    send_detection(make_det(OP_COMPARE, '0, 200, 200, 10, 10, 0, 0, 7, 16384, 2));

    // Tagged reference with a position and no box
    send_detection(make_det(OP_LOAD, 32'h1234_5678, 0, 0, 0, 0, 100, -100, 0, 0, 0));
    send_detection(make_det(OP_COMPARE, 32'h1234_5678, 0, 0, 0, 0, -5000, 5000, 0, 0, 0));
    // Squared distance equal to the limit misses, one unit closer hits
    send_detection(make_det(OP_COMPARE, '0, 0, 0, 0, 0, 260, -100, 1, 0, 0));
    send_detection(make_det(OP_COMPARE, '0, 0, 0, 0, 0, 259, -100, 1, 0, 0));
    wait_drained();
  endtask

  // Fill the block behind a long receiver hold, then let the receiver drain it
  task automatic test_backpressure();
    stall_mode = STALL_NONE;
    send_detection(random_load());
    hold_request = 300;
    repeat (50) begin
      if ($urandom_range(0, 4) == 0)
        send_detection(random_load());
      else
        send_detection(near_compare());
    end
    // Pause until every owed verdict is in, then resume under light stalls
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_wr != verdict_rd) @(posedge clk);
    stall_mode = STALL_LIGHT;
    repeat (20) send_detection(near_compare());
    wait_drained();
  endtask

  // Random traffic under a series of register settings, extremes included
  task automatic test_register_phases();
    logic [31:0] phase_regs [5][4];
    phase_regs[0] = '{32'd0, 32'd0, 32'd0, 32'd0};
    phase_regs[1] = '{32'd32768, 32'hffff_ffff, 32'd255, 32'd0};
    phase_regs[2] = '{32'd16384, 32'd25600, 32'd1, 32'd2};
    phase_regs[3] = '{$urandom_range(0, 32768), $urandom_range(0, 32'h000f_ffff), 32'd5, 32'd5};
    phase_regs[4] = '{$urandom_range(0, 32768), $urandom, $urandom_range(0, 255),
                      $urandom_range(0, 255)};
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_CONF_GAP, phase_regs[p][0]);
      write_reg(REG_DIST_SQ,  phase_regs[p][1]);
      write_reg(REG_NORMAL,   phase_regs[p][2]);
      write_reg(REG_CRITICAL, phase_regs[p][3]);
      stall_mode = p % 3;
      random_traffic(240);
      wait_drained();
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_operation     = OP_LOAD;
    in_target_tag    = '0;
    in_box_x         = '0;
    in_box_y         = '0;
    in_box_w         = '0;
    in_box_h         = '0;
    in_geo_x         = '0;
    in_geo_y         = '0;
    in_class_code    = '0;
    in_confidence    = '0;
    in_decision_code = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;

    // Shadow state after reset
    held_ref      = make_det(OP_LOAD, '0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    gap_limit     = CONF_GAP_RST;
    dist_limit    = DIST_SQ_RST;
    normal_code   = NORMAL_RST;
    critical_code = CRITICAL_RST;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_defaults();
    test_compare_before_load();
    test_directed_cases();
    test_backpressure();
    test_register_phases();
    wait_drained();

    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/dpcc_pkg.sv
hw/rtl/dpcc_eval.sv
hw/rtl/detection_pair_conflict_check.sv
tb/tb_detection_pair_conflict_check.sv
